>>> src/xoshiro_pkg.sv
// ----------------------------------------------------------------------------
// xoshiro_pkg
// Shared types and constants of the xoshiro256** generator.
// ----------------------------------------------------------------------------
package xoshiro_pkg;

    localparam logic [1:0] MODE_SEED    = 2'd0;
    localparam logic [1:0] MODE_NEXT64  = 2'd1;
    localparam logic [1:0] MODE_NEXT32  = 2'd2;
    localparam logic [1:0] MODE_BOUNDED = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNSEEDED = 2'd1;
    localparam logic [1:0] STATUS_IGNORED  = 2'd2;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    localparam int QUEUE_DEPTH = 2;

    // one classified request as it travels through the queue
    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] seed_value;
        logic [31:0] bound;
        logic [31:0] offset;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM_MUL_A,
        ST_SM_MUL_B,
        ST_SM_FIN,
        ST_DRAW,
        ST_BND_MUL,
        ST_BND_CHECK,
        ST_THR_DIV,
        ST_THR_CHECK,
        ST_OUT
    } state_t;

endpackage

>>> src/xoshiro_front.sv
// ----------------------------------------------------------------------------
// xoshiro_front
// Accept request items and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module xoshiro_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  xoshiro_pkg::req_t   in_req,
    output logic                q_valid,
    input  logic                q_ready,
    output xoshiro_pkg::req_t   q_req
);

    xoshiro_pkg::req_t slot_reg [xoshiro_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'(xoshiro_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> src/xoshiro_back.sv
// ----------------------------------------------------------------------------
// xoshiro_back
// Carry out one request: seed, draw, cached half, bounded draw or status-only reply.
// ----------------------------------------------------------------------------
module xoshiro_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  xoshiro_pkg::req_t   q_req,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         out_value,
    output logic [1:0]          out_status
);

    xoshiro_pkg::state_t state_reg, state_next;

    logic [63:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic [31:0] cache_reg;
    logic        cache_valid_reg;
    logic        seeded_reg;

    xoshiro_pkg::req_t req_reg;
    logic [63:0] ctr_reg;
    logic [63:0] z_reg;
    logic [63:0] acc_reg;
    logic [1:0]  mul_step_reg;
    logic [1:0]  sm_idx_reg;
    logic [63:0] prod_reg;
    logic [31:0] thr_reg;
    logic        thr_known_reg;
    logic [31:0] rem_reg;
    logic [32:0] num_reg;
    logic [5:0]  div_cnt_reg;
    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic [1:0]  status_reg;
    logic [63:0] res_value_reg;
    logic [1:0]  res_status_reg;

    logic [63:0] word;
    logic [63:0] n0, n1, n2, n3, t17;
    logic [63:0] ctr_inc;
    logic [63:0] mix_out;
    logic [32:0] rem_sh;
    logic        out_free;
    logic [63:0] mul_op;
    logic [63:0] mul_k;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] mul_sum;

    // xoshiro256** output and one state advance
    always_comb
    begin
        word = s1_reg * 64'd5;
        word = {word[56:0], word[63:57]} * 64'd9;
        t17  = s1_reg << 17;
        n2   = s2_reg ^ s0_reg;
        n3   = s3_reg ^ s1_reg;
        n1   = s1_reg ^ n2;
        n0   = s0_reg ^ n3;
        n2   = n2 ^ t17;
        n3   = {n3[18:0], n3[63:19]};
    end

    // 64-bit product by a mixing constant, one 32x32 partial product a cycle:
    // low x low, then low x high and high x low into the upper half
    always_comb
    begin
        if (state_reg == xoshiro_pkg::ST_SM_MUL_A)
        begin
            mul_op = ctr_inc ^ (ctr_inc >> 30);
            mul_k  = xoshiro_pkg::MIX_MUL_A;
        end
        else
        begin
            mul_op = z_reg ^ (z_reg >> 27);
            mul_k  = xoshiro_pkg::MIX_MUL_B;
        end
        mul_x = (mul_step_reg == 2'd2) ? mul_op[63:32] : mul_op[31:0];
        mul_y = (mul_step_reg == 2'd1) ? mul_k[63:32] : mul_k[31:0];
        mul_p = {32'd0, mul_x} * {32'd0, mul_y};
        if (mul_step_reg == 2'd0)
            mul_sum = mul_p;
        else
            mul_sum = acc_reg + {mul_p[31:0], 32'd0};
    end

    assign ctr_inc  = ctr_reg + xoshiro_pkg::GOLDEN_GAMMA;
    assign mix_out  = z_reg ^ (z_reg >> 31);
    assign rem_sh   = {rem_reg, num_reg[32]};
    assign out_free = !out_valid_reg || out_ready;

    assign q_ready    = (state_reg == xoshiro_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_value  = value_reg;
    assign out_status = status_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xoshiro_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_req.mode == xoshiro_pkg::MODE_SEED && !seeded_reg)
                        state_next = xoshiro_pkg::ST_SM_MUL_A;
                    else if (q_req.mode == xoshiro_pkg::MODE_SEED || !seeded_reg)
                        state_next = xoshiro_pkg::ST_OUT;
                    else if (q_req.mode == xoshiro_pkg::MODE_NEXT32 && cache_valid_reg)
                        state_next = xoshiro_pkg::ST_OUT;
                    else
                        state_next = xoshiro_pkg::ST_DRAW;
                end
            end
            xoshiro_pkg::ST_SM_MUL_A:
            begin
                if (mul_step_reg == 2'd2)
                    state_next = xoshiro_pkg::ST_SM_MUL_B;
            end
            xoshiro_pkg::ST_SM_MUL_B:
            begin
                if (mul_step_reg == 2'd2)
                    state_next = xoshiro_pkg::ST_SM_FIN;
            end
            xoshiro_pkg::ST_SM_FIN:
            begin
                if (sm_idx_reg == 2'd3)
                    state_next = xoshiro_pkg::ST_OUT;
                else
                    state_next = xoshiro_pkg::ST_SM_MUL_A;
            end
            xoshiro_pkg::ST_DRAW:
            begin
                if (req_reg.mode == xoshiro_pkg::MODE_BOUNDED)
                    state_next = xoshiro_pkg::ST_BND_MUL;
                else
                    state_next = xoshiro_pkg::ST_OUT;
            end
            xoshiro_pkg::ST_BND_MUL:   state_next = xoshiro_pkg::ST_BND_CHECK;
            xoshiro_pkg::ST_BND_CHECK:
            begin
                if (prod_reg[31:0] >= req_reg.bound)
                    state_next = xoshiro_pkg::ST_OUT;
                else if (thr_known_reg)
                    state_next = xoshiro_pkg::ST_THR_CHECK;
                else
                    state_next = xoshiro_pkg::ST_THR_DIV;
            end
            xoshiro_pkg::ST_THR_DIV:
            begin
                if (div_cnt_reg == 6'd32)
                    state_next = xoshiro_pkg::ST_THR_CHECK;
            end
            xoshiro_pkg::ST_THR_CHECK:
            begin
                if (prod_reg[31:0] >= thr_reg)
                    state_next = xoshiro_pkg::ST_OUT;
                else
                    state_next = xoshiro_pkg::ST_DRAW;
            end
            xoshiro_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = xoshiro_pkg::ST_IDLE;
            end
            default: state_next = xoshiro_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= xoshiro_pkg::ST_IDLE;
            s0_reg          <= 64'd0;
            s1_reg          <= 64'd0;
            s2_reg          <= 64'd0;
            s3_reg          <= 64'd0;
            cache_reg       <= 32'd0;
            cache_valid_reg <= 1'b0;
            seeded_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            value_reg       <= 64'd0;
            status_reg      <= xoshiro_pkg::STATUS_OK;
            res_value_reg   <= 64'd0;
            res_status_reg  <= xoshiro_pkg::STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            // load the output register once the previous item is gone
            if (state_reg == xoshiro_pkg::ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                value_reg     <= res_value_reg;
                status_reg    <= res_status_reg;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                xoshiro_pkg::ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        res_value_reg  <= 64'd0;
                        res_status_reg <= xoshiro_pkg::STATUS_OK;
                        if (q_req.mode == xoshiro_pkg::MODE_SEED)
                        begin
                            if (seeded_reg)
                                res_status_reg <= xoshiro_pkg::STATUS_IGNORED;
                        end
                        else if (!seeded_reg)
                            res_status_reg <= xoshiro_pkg::STATUS_UNSEEDED;
                        else if (q_req.mode == xoshiro_pkg::MODE_NEXT32 && cache_valid_reg)
                        begin
                            res_value_reg   <= {32'd0, cache_reg};
                            cache_valid_reg <= 1'b0;
                        end
                    end
                end
                xoshiro_pkg::ST_SM_FIN:
                begin
                    s0_reg <= s1_reg;
                    s1_reg <= s2_reg;
                    s2_reg <= s3_reg;
                    s3_reg <= mix_out;
                    if (sm_idx_reg == 2'd3)
                    begin
                        cache_reg       <= 32'd0;
                        cache_valid_reg <= 1'b0;
                        seeded_reg      <= 1'b1;
                    end
                end
                xoshiro_pkg::ST_DRAW:
                begin
                    s0_reg <= n0;
                    s1_reg <= n1;
                    s2_reg <= n2;
                    s3_reg <= n3;
                    if (req_reg.mode == xoshiro_pkg::MODE_NEXT64)
                        res_value_reg <= word;
                    else if (req_reg.mode == xoshiro_pkg::MODE_NEXT32)
                    begin
                        res_value_reg   <= {32'd0, word[31:0]};
                        cache_reg       <= word[63:32];
                        cache_valid_reg <= 1'b1;
                    end
                end
                xoshiro_pkg::ST_BND_CHECK:
                begin
                    if (prod_reg[31:0] >= req_reg.bound)
                        res_value_reg <= {32'd0, prod_reg[63:32] + req_reg.offset};
                end
                xoshiro_pkg::ST_THR_CHECK:
                begin
                    if (prod_reg[31:0] >= thr_reg)
                        res_value_reg <= {32'd0, prod_reg[63:32] + req_reg.offset};
                end
                default: ;
            endcase
        end
    end

    // working registers of the current item
    always_ff @(posedge clk)
    begin
        case (state_reg)
            xoshiro_pkg::ST_IDLE:
            begin
                req_reg       <= q_req;
                ctr_reg       <= q_req.seed_value;
                sm_idx_reg    <= 2'd0;
                mul_step_reg  <= 2'd0;
                thr_known_reg <= 1'b0;
            end
            xoshiro_pkg::ST_SM_MUL_A:
            begin
                acc_reg <= mul_sum;
                if (mul_step_reg == 2'd2)
                begin
                    mul_step_reg <= 2'd0;
                    ctr_reg      <= ctr_inc;
                    z_reg        <= mul_sum;
                end
                else
                    mul_step_reg <= mul_step_reg + 2'd1;
            end
            xoshiro_pkg::ST_SM_MUL_B:
            begin
                acc_reg <= mul_sum;
                if (mul_step_reg == 2'd2)
                begin
                    mul_step_reg <= 2'd0;
                    z_reg        <= mul_sum;
                end
                else
                    mul_step_reg <= mul_step_reg + 2'd1;
            end
            xoshiro_pkg::ST_SM_FIN:
                sm_idx_reg <= sm_idx_reg + 2'd1;
            xoshiro_pkg::ST_DRAW:
                z_reg <= word;
            xoshiro_pkg::ST_BND_MUL:
                prod_reg <= {32'd0, z_reg[31:0]} * {32'd0, req_reg.bound};
            xoshiro_pkg::ST_BND_CHECK:
            begin
                // restoring divide of 2^32 - bound by bound, one bit a cycle
                num_reg     <= {32'd0 - req_reg.bound, 1'b0};
                rem_reg     <= 32'd0;
                div_cnt_reg <= 6'd0;
            end
            xoshiro_pkg::ST_THR_DIV:
            begin
                if (div_cnt_reg != 6'd32)
                begin
                    num_reg     <= {num_reg[31:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (rem_sh >= {1'b0, req_reg.bound})
                        rem_reg <= 32'(rem_sh - {1'b0, req_reg.bound});
                    else
                        rem_reg <= rem_sh[31:0];
                end
                else
                begin
                    thr_reg       <= rem_reg;
                    thr_known_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> src/xoshiro256ss_generator.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_generator
// xoshiro256** generator with splitmix64 seeding and bounded draws.
// ----------------------------------------------------------------------------
// Steps of the back-end sequencer: a cached half or a status-only item passes idle and
// output, a plain draw idle, draw and output, a bounded draw also a multiply and a check;
// seeding builds each state word with splitmix64 from 32x32 partial products. A new item
// is taken only once the last has left the output step. A bounded draw that hits the
// rejection zone runs the threshold divider once per item and redraws while below it.
// Reset: asynchronous, active low; state words, cache and seeded flag clear.
module xoshiro256ss_generator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // seed_value[63:0], bound[95:64], offset[127:96]
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // value[63:0]
    output logic [1:0]   m_tuser    // status[1:0]
);

    xoshiro_pkg::req_t in_req;
    xoshiro_pkg::req_t q_req;
    logic              q_valid;
    logic              q_ready;

    // classify the incoming item into a request record
    always_comb
    begin
        in_req.mode       = s_tuser;
        in_req.seed_value = s_tdata[63:0];
        in_req.bound      = s_tdata[95:64];
        in_req.offset     = s_tdata[127:96];
    end

    xoshiro_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    xoshiro_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata),
        .out_status (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // a status other than ok always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != xoshiro_pkg::STATUS_OK |-> m_tdata == 64'd0)
    else $error("error status with nonzero value");

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

    // the back end takes no new item while a result is being produced
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> !q_ready)
    else $error("back end accepted two items in a row");
`endif

endmodule
